@@ rtl/pidwi_pkg.sv @@
`default_nettype none
package pidwi_pkg;

	localparam int unsigned VAL_W = 32;
	localparam int unsigned DT_W = 16;
	localparam int unsigned LIM_W = 31;
	localparam int unsigned IDX_W = 4;

	localparam logic [IDX_W-1:0] REG_KF = 4'd0;
	localparam logic [IDX_W-1:0] REG_KP = 4'd1;
	localparam logic [IDX_W-1:0] REG_KI = 4'd2;
	localparam logic [IDX_W-1:0] REG_KD = 4'd3;
	localparam logic [IDX_W-1:0] REG_MAX_ERR = 4'd4;
	localparam logic [IDX_W-1:0] REG_MAX_INT = 4'd5;
	localparam logic [IDX_W-1:0] REG_MAX_OUT = 4'd6;
	localparam logic [IDX_W-1:0] REG_TAU = 4'd7;

	localparam logic [LIM_W-1:0] MAX_ERR_RST = 31'd65536;
	localparam logic [DT_W-1:0] TAU_RST = 16'd1043;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ESQ,
		S_DEN,
		S_WSET,
		S_WDIV,
		S_WDT,
		S_INC,
		S_INT,
		S_RDIV,
		S_ASET,
		S_ADIV,
		S_FRM,
		S_FR,
		S_KP,
		S_KI,
		S_KD,
		S_SUM
	} pidwi_state_t;

endpackage
`default_nettype wire

@@ rtl/pidwi_if.sv @@
`default_nettype none
interface pidwi_cmd_if import pidwi_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VAL_W-1:0] setpoint;
	logic signed [VAL_W-1:0] measurement;
	logic [DT_W-1:0] time_step;
	modport source(output valid, setpoint, measurement, time_step, input ready);
	modport sink(input valid, setpoint, measurement, time_step, output ready);
endinterface

interface pidwi_rsp_if import pidwi_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VAL_W-1:0] control_out;
	modport source(output valid, control_out, input ready);
	modport sink(input valid, control_out, output ready);
endinterface

interface pidwi_cfg_if import pidwi_pkg::*; ();
	logic valid;
	logic ready;
	logic [IDX_W-1:0] index;
	logic [VAL_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/positional_pid_weighted_integral.sv @@
// Items are handled one at a time: a new item is accepted only while idle, once the
// previous result is registered (the weight or rate division is skipped when it saturates).
// Built on one shared 32x32 multiplier and one radix-2 restoring divider that run
// the weight (16 steps), rate (32 steps) and filter coefficient (17 steps).
// Reset (arst_n low, asynchronous): registers to defaults, state cleared, idle.
`default_nettype none
module positional_pid_weighted_integral import pidwi_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	pidwi_cmd_if.sink cmd,
	pidwi_rsp_if.source rsp,
	pidwi_cfg_if.sink cfg
);

	// configuration registers
	logic [31:0] kf_q, kp_q, ki_q, kd_q;
	logic [30:0] max_err_q, max_int_q, max_out_q;
	logic [15:0] tau_q;

	// item and controller state
	pidwi_state_t state_q, state_d;
	logic signed [31:0] sp_q, meas_q, e_q;
	logic [15:0] dt_q;
	logic signed [31:0] integ_q, fr_q, prev_q, raw_q;
	logic [16:0] w_q;
	logic signed [50:0] acc_q;
	logic out_v_q;
	logic signed [31:0] out_q;

	// shared multiplier
	logic mul_en, mul_neg, mneg_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;

	// shared divider
	logic [62:0] rem_q, dvs_q;
	logic [31:0] low_q, q_q;
	logic [5:0] cnt_q;
	logic [63:0] div_t, div_r;
	logic div_ge;
	logic [31:0] div_qn;

	function automatic logic [31:0] abs32(input logic signed [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	function automatic logic signed [50:0] clamp51(input logic signed [50:0] v,
			input logic [30:0] lim);
		logic signed [50:0] l;
		l = signed'({20'b0, lim});
		if (v > l) return l;
		else if (v < -l) return -l;
		else return v;
	endfunction

	// product rounded half away from zero at bit 16 (and at bit 32 for inc), sign applied
	logic [63:0] r16_sum, r32_sum;
	logic signed [50:0] term16;
	logic signed [33:0] inc;
	assign r16_sum = prod_q + 64'h8000;
	assign r32_sum = prod_q + 64'h8000_0000;
	assign term16 = mneg_q ? -signed'({3'b0, r16_sum[63:16]}) : signed'({3'b0, r16_sum[63:16]});
	assign inc = mneg_q ? -signed'({2'b0, r32_sum[63:32]}) : signed'({2'b0, r32_sum[63:32]});

	// error at accept, saturated
	logic signed [32:0] ediff;
	logic signed [31:0] e_in;
	assign ediff = {cmd.setpoint[31], cmd.setpoint} - {cmd.measurement[31], cmd.measurement};
	always_comb begin
		if (ediff[32] != ediff[31]) begin
			e_in = ediff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			e_in = ediff[31:0];
		end
	end

	logic [31:0] emag;
	assign emag = abs32(e_q);

	// rate dividend: |meas - prev| << 16 plus half the step
	logic signed [32:0] rdiff;
	logic rneg;
	logic [32:0] rmag;
	logic [48:0] rdvd;
	logic rovf;
	assign rdiff = {meas_q[31], meas_q} - {prev_q[31], prev_q};
	assign rneg = rdiff[32];
	assign rmag = rneg ? 33'(-rdiff) : 33'(rdiff);
	assign rdvd = {rmag, 16'b0} + {34'b0, dt_q[15:1]};
	assign rovf = rdvd[48:32] >= {1'b0, dt_q};

	// filter coefficient dividend
	logic [16:0] tot;
	logic [32:0] advd;
	assign tot = {1'b0, dt_q} + {1'b0, tau_q};
	assign advd = {1'b0, dt_q, 16'b0} + {17'b0, tot[16:1]};

	// filter step operand
	logic signed [32:0] fdiff;
	logic [32:0] fmag;
	assign fdiff = {raw_q[31], raw_q} - {fr_q[31], fr_q};
	assign fmag = fdiff[32] ? 33'(-fdiff) : 33'(fdiff);

	// divider step: shift in one dividend bit, trial subtract
	assign div_t = {rem_q, low_q[31]};
	assign div_ge = div_t >= {1'b0, dvs_q};
	assign div_r = div_ge ? div_t - {1'b0, dvs_q} : div_t;
	assign div_qn = {q_q[30:0], div_ge};

	// saturate the rate quotient with its sign
	logic signed [31:0] raw_sat;
	always_comb begin
		if (rneg) begin
			raw_sat = (div_qn > 32'h8000_0000) ? 32'sh8000_0000 : signed'(~div_qn + 32'd1);
		end else begin
			raw_sat = div_qn[31] ? 32'sh7FFF_FFFF : signed'(div_qn);
		end
	end

	logic signed [50:0] isum, fsum, osum;
	assign isum = clamp51(51'(integ_q) + 51'(inc), max_int_q);
	assign fsum = 51'(fr_q) + term16;
	assign osum = clamp51(acc_q - term16, max_out_q);

	logic in_acc, out_free;
	assign in_acc = cmd.valid && cmd.ready;
	assign out_free = !out_v_q || rsp.ready;

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_v_q;
	assign rsp.control_out = out_q;

	// next state and multiplier issue
	always_comb begin
		state_d = state_q;
		mul_en = 1'b0;
		mul_a = '0;
		mul_b = '0;
		mul_neg = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) state_d = S_ESQ;
			end
			S_ESQ: begin
				mul_en = 1'b1; mul_a = emag; mul_b = emag;
				state_d = S_DEN;
			end
			S_DEN: begin
				mul_en = 1'b1; mul_a = {1'b0, max_err_q}; mul_b = {1'b0, max_err_q};
				state_d = S_WSET;
			end
			S_WSET: begin
				state_d = (rem_q >= prod_q[62:0]) ? S_WDT : S_WDIV;
			end
			S_WDIV: begin
				if (cnt_q == 6'd1) state_d = S_WDT;
			end
			S_WDT: begin
				mul_en = 1'b1; mul_a = {15'b0, w_q}; mul_b = {16'b0, dt_q};
				state_d = S_INC;
			end
			S_INC: begin
				mul_en = 1'b1; mul_a = emag; mul_b = prod_q[31:0]; mul_neg = e_q[31];
				state_d = S_INT;
			end
			S_INT: begin
				state_d = rovf ? S_ASET : S_RDIV;
			end
			S_RDIV: begin
				if (cnt_q == 6'd1) state_d = S_ASET;
			end
			S_ASET: begin
				state_d = S_ADIV;
			end
			S_ADIV: begin
				if (cnt_q == 6'd1) state_d = S_FRM;
			end
			S_FRM: begin
				mul_en = 1'b1; mul_a = fmag[31:0]; mul_b = {15'b0, q_q[16:0]};
				mul_neg = fdiff[32];
				state_d = S_FR;
			end
			S_FR: begin
				mul_en = 1'b1; mul_a = abs32(sp_q); mul_b = kf_q; mul_neg = sp_q[31];
				state_d = S_KP;
			end
			S_KP: begin
				mul_en = 1'b1; mul_a = emag; mul_b = kp_q; mul_neg = e_q[31];
				state_d = S_KI;
			end
			S_KI: begin
				mul_en = 1'b1; mul_a = abs32(integ_q); mul_b = ki_q; mul_neg = integ_q[31];
				state_d = S_KD;
			end
			S_KD: begin
				mul_en = 1'b1; mul_a = abs32(fr_q); mul_b = kd_q; mul_neg = fr_q[31];
				state_d = S_SUM;
			end
			S_SUM: begin
				// hold until the output register is free
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kf_q <= '0; kp_q <= '0; ki_q <= '0; kd_q <= '0;
			max_err_q <= MAX_ERR_RST; max_int_q <= '0; max_out_q <= '0;
			tau_q <= TAU_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_KF: kf_q <= cfg.data;
				REG_KP: kp_q <= cfg.data;
				REG_KI: ki_q <= cfg.data;
				REG_KD: kd_q <= cfg.data;
				REG_MAX_ERR: max_err_q <= cfg.data[30:0];
				REG_MAX_INT: max_int_q <= cfg.data[30:0];
				REG_MAX_OUT: max_out_q <= cfg.data[30:0];
				REG_TAU: tau_q <= cfg.data[15:0];
				default: ; // drop writes past the register list
			endcase
		end
	end

	// controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			fr_q <= '0;
			prev_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (state_q == S_INT) integ_q <= isum[31:0];
			if (state_q == S_FR) fr_q <= fsum[31:0];
			if (state_q == S_SUM && out_free) begin
				out_v_q <= 1'b1;
				prev_q <= meas_q;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
			mneg_q <= mul_neg;
		end
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					sp_q <= cmd.setpoint;
					meas_q <= cmd.measurement;
					dt_q <= (cmd.time_step == '0) ? 16'd1 : cmd.time_step;
					e_q <= e_in;
				end
			end
			S_DEN: rem_q <= prod_q[62:0];
			S_WSET: begin
				w_q <= '0;
				dvs_q <= prod_q[62:0];
				low_q <= '0;
				q_q <= '0;
				cnt_q <= 6'd16;
			end
			S_WDIV, S_RDIV, S_ADIV: begin
				rem_q <= div_r[62:0];
				low_q <= {low_q[30:0], 1'b0};
				q_q <= div_qn;
				cnt_q <= cnt_q - 6'd1;
				if (state_q == S_WDIV) w_q <= 17'h10000 - {1'b0, div_qn[15:0]};
				if (state_q == S_RDIV) raw_q <= raw_sat;
			end
			S_INT: begin
				raw_q <= rneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				rem_q <= {46'b0, rdvd[48:32]};
				low_q <= rdvd[31:0];
				dvs_q <= {47'b0, dt_q};
				q_q <= '0;
				cnt_q <= 6'd32;
			end
			S_ASET: begin
				rem_q <= {47'b0, advd[32:17]};
				low_q <= {advd[16:0], 15'b0};
				dvs_q <= {46'b0, tot};
				q_q <= '0;
				cnt_q <= 6'd17;
			end
			S_KP: acc_q <= term16;
			S_KI: acc_q <= acc_q + term16;
			S_KD: acc_q <= acc_q + term16;
			S_SUM: begin
				if (out_free) out_q <= osum[31:0];
			end
			default: ;
		endcase
	end

	// checks
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WDIV || state_q == S_RDIV || state_q == S_ADIV) |-> cnt_q != 6'd0)
		else $error("divider running with zero step count");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_ESQ)
		else $error("accepted item did not start the sequence");

	a_rsp_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == S_SUM))
		else $error("result raised outside the final step");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WDT |-> w_q <= 17'h10000)
		else $error("integral weight above one");

endmodule
`default_nettype wire
